// ----- rtl/core/dsre_pkg.sv -----
// shared types and constants of the dual stack rotate engine
// no dependencies; every other file imports it
package dsre_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DW        = 32;
  localparam int MODE_W    = 4;
  localparam int CNT_W     = 7;
  localparam int STAT_W    = 2;
  localparam int GRP       = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 4'd0,
    MODE_SA   = 4'd1,
    MODE_SB   = 4'd2,
    MODE_SS   = 4'd3,
    MODE_PA   = 4'd4,
    MODE_PB   = 4'd5,
    MODE_RA   = 4'd6,
    MODE_RB   = 4'd7,
    MODE_RR   = 4'd8,
    MODE_RRA  = 4'd9,
    MODE_RRB  = 4'd10,
    MODE_RRR  = 4'd11
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SWAP,
    OP_UP,
    OP_ROTUP,
    OP_DOWN,
    OP_LOAD
  } cell_op_t;

  typedef enum logic [1:0] {
    INJ_EXT,
    INJ_TOP,
    INJ_BOT
  } inj_sel_t;

  typedef struct packed {
    cell_op_t op;
    inj_sel_t inj;
  } stk_ctl_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_GATHER
  } fsm_t;

endpackage

// ----- rtl/core/dsre_in_if.sv -----
// input channel: operation beat with valid/ready handshake
// depends on dsre_pkg
interface dsre_in_if import dsre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic signed [DW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ----- rtl/core/dsre_out_if.sv -----
// result channel: tops, counts and status with valid/ready handshake
// depends on dsre_pkg
interface dsre_out_if import dsre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] top_of_a;
  logic signed [DW-1:0] top_of_b;
  logic [CNT_W-1:0]     count_of_a;
  logic [CNT_W-1:0]     count_of_b;
  logic [STAT_W-1:0]    status;

  modport source (output valid, output top_of_a, output top_of_b, output count_of_a,
                  output count_of_b, output status, input ready);
  modport sink   (input valid, input top_of_a, input top_of_b, input count_of_a,
                  input count_of_b, input status, output ready);
endinterface

// ----- rtl/core/dual_stack_rotate_engine_top.sv -----
// Two bounded stacks of 32-bit words, each a row of DEPTH shift cells with entry 0 on
// top. Load, swap, push and rotate items are applied when taken; reverse rotates (rra,
// rrb, rrr) are applied in a gather state once each stack's registered group reduction
// holds the bottom word. Every item gives one result beat, held in an output register;
// the next item is taken outside the gather state while that register is free or being
// drained. Stack contents need no clearing: only state, fill counters and valid reset.
// depends on dsre_pkg, dsre_in_if, dsre_out_if, dsre_ctrl and dsre_stack
module dual_stack_rotate_engine_top import dsre_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dsre_in_if.sink    in_ch,
  dsre_out_if.source out_ch
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [FW-1:0] fill_a, fill_b;
  stk_ctl_t      ctl_a, ctl_b;
  logic [DW-1:0] ext_a, ext_b;
  logic [DW-1:0] a_top, b_top, a_top_nxt, b_top_nxt;

  dsre_ctrl #(
    .DEPTH (DEPTH),
    .FW    (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .a_top     (a_top),
    .b_top     (b_top),
    .a_top_nxt (a_top_nxt),
    .b_top_nxt (b_top_nxt),
    .fill_a    (fill_a),
    .fill_b    (fill_b),
    .ctl_a     (ctl_a),
    .ctl_b     (ctl_b),
    .ext_a     (ext_a),
    .ext_b     (ext_b)
  );

  dsre_stack #(
    .DEPTH (DEPTH),
    .FW    (FW)
  ) u_stack_a (
    .clk     (clk),
    .ctl     (ctl_a),
    .fill    (fill_a),
    .ext     (ext_a),
    .top     (a_top),
    .top_nxt (a_top_nxt)
  );

  dsre_stack #(
    .DEPTH (DEPTH),
    .FW    (FW)
  ) u_stack_b (
    .clk     (clk),
    .ctl     (ctl_b),
    .fill    (fill_b),
    .ext     (ext_b),
    .top     (b_top),
    .top_nxt (b_top_nxt)
  );

endmodule

// ----- rtl/core/dsre_cell.sv -----
// one stack entry: holds a word and takes it from a neighbor or the inject bus
// depends on dsre_pkg
module dsre_cell import dsre_pkg::*; #(
  parameter int FW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  stk_ctl_t          ctl,
  input  logic [FW-1:0]     fill,
  input  logic [DW-1:0]     above,
  input  logic [DW-1:0]     below,
  input  logic [DW-1:0]     inj,
  output logic [DW-1:0]     d,
  output logic [DW-1:0]     d_nxt,
  output logic [DW-1:0]     gath
);

  localparam logic [FW-1:0] IDX_V  = FW'(IDX);
  localparam logic [FW-1:0] LAST_V = FW'(IDX + 1);
  localparam bit IS_FIRST  = (IDX == 0);
  localparam bit IS_SECOND = (IDX == 1);

  logic [DW-1:0] d_r;
  logic          is_last;
  logic          at_fill;

  assign is_last = (fill == LAST_V);
  assign at_fill = (fill == IDX_V);

  always_comb begin
    unique case (ctl.op)
      OP_SWAP: begin
        if (IS_FIRST) begin
          d_nxt = below;
        end else if (IS_SECOND) begin
          d_nxt = above;
        end else begin
          d_nxt = d_r;
        end
      end
      OP_UP:    d_nxt = below;
      OP_ROTUP: d_nxt = is_last ? inj : below;
      OP_DOWN:  d_nxt = above;
      OP_LOAD:  d_nxt = at_fill ? inj : d_r;
      default:  d_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d    = d_r;
  assign gath = is_last ? d_r : '0;

endmodule

// ----- rtl/core/dsre_stack.sv -----
// one stack as a row of cells, entry 0 on top, with a registered bottom reduction
// depends on dsre_pkg and dsre_cell
module dsre_stack import dsre_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  stk_ctl_t      ctl,
  input  logic [FW-1:0] fill,
  input  logic [DW-1:0] ext,
  output logic [DW-1:0] top,
  output logic [DW-1:0] top_nxt
);

  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  logic [DW-1:0] d     [DEPTH];
  logic [DW-1:0] dn    [DEPTH];
  logic [DW-1:0] gath  [DEPTH];
  logic [DW-1:0] ab    [DEPTH];
  logic [DW-1:0] bl    [DEPTH];
  logic [DW-1:0] grp_nxt [NGRP];
  logic [DW-1:0] grp_r   [NGRP];
  logic [DW-1:0] bot;
  logic [DW-1:0] inj;

  always_comb begin
    case (ctl.inj)
      INJ_TOP: inj = d[0];
      INJ_BOT: inj = bot;
      default: inj = ext;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign ab[i] = inj;
    end else begin : g_mid_a
      assign ab[i] = d[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign bl[i] = d[i];
    end else begin : g_mid_b
      assign bl[i] = d[i+1];
    end

    dsre_cell #(
      .FW  (FW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .fill  (fill),
      .above (ab[i]),
      .below (bl[i]),
      .inj   (inj),
      .d     (d[i]),
      .d_nxt (dn[i]),
      .gath  (gath[i])
    );
  end

  // bottom word: one-hot or over groups, registered per group
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int LO = g * GRP;
    localparam int N  = (DEPTH - LO < GRP) ? (DEPTH - LO) : GRP;

    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < N; k++) begin
        grp_nxt[g] = grp_nxt[g] | gath[LO + k];
      end
    end

    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    bot = '0;
    for (int g = 0; g < NGRP; g++) begin
      bot = bot | grp_r[g];
    end
  end

  assign top     = d[0];
  assign top_nxt = dn[0];

endmodule

// ----- rtl/core/dsre_ctrl.sv -----
// handshake, operation decode, fill counters and result register
// depends on dsre_pkg, dsre_in_if and dsre_out_if
module dsre_ctrl import dsre_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  dsre_in_if.sink       in_ch,
  dsre_out_if.source    out_ch,
  input  logic [DW-1:0] a_top,
  input  logic [DW-1:0] b_top,
  input  logic [DW-1:0] a_top_nxt,
  input  logic [DW-1:0] b_top_nxt,
  output logic [FW-1:0] fill_a,
  output logic [FW-1:0] fill_b,
  output stk_ctl_t      ctl_a,
  output stk_ctl_t      ctl_b,
  output logic [DW-1:0] ext_a,
  output logic [DW-1:0] ext_b
);

  localparam logic [FW-1:0] FULL_V = FW'(DEPTH);
  localparam logic [FW-1:0] TWO_V  = FW'(2);
  localparam logic [FW-1:0] ONE_V  = FW'(1);

  fsm_t              state_r, state_nxt;
  mode_t             mode_r;
  mode_t             in_mode;
  mode_t             op_mode;
  logic              in_fire;
  logic              is_rdn;
  logic              apply;
  logic [FW-1:0]     fill_a_r, fill_a_nxt;
  logic [FW-1:0]     fill_b_r, fill_b_nxt;
  status_t           status;
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     top_a_r, top_b_r;
  logic [CNT_W-1:0]  cnt_a_r, cnt_b_r;
  logic [STAT_W-1:0] status_r;
  logic              ok_a, ok_b, full_a, full_b, empty_a, empty_b;
  logic              wa, wb;
  cell_op_t          sop;

  assign in_mode = mode_t'(in_ch.mode);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_rdn  = (in_mode == MODE_RRA) || (in_mode == MODE_RRB) || (in_mode == MODE_RRR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:   if (in_fire && is_rdn) state_nxt = FSM_GATHER;
      FSM_GATHER: state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    op_mode     = in_mode;
    apply       = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ch.ready = !out_valid_r || out_ch.ready;
        apply       = in_fire && !is_rdn;
      end
      FSM_GATHER: begin
        op_mode = mode_r;
        apply   = 1'b1;
      end
      default: ;
    endcase
  end

  assign ok_a    = (fill_a_r >= TWO_V);
  assign ok_b    = (fill_b_r >= TWO_V);
  assign full_a  = (fill_a_r == FULL_V);
  assign full_b  = (fill_b_r == FULL_V);
  assign empty_a = (fill_a_r == '0);
  assign empty_b = (fill_b_r == '0);

  always_comb begin
    ctl_a      = '{op: OP_HOLD, inj: INJ_EXT};
    ctl_b      = '{op: OP_HOLD, inj: INJ_EXT};
    status     = STAT_DONE;
    fill_a_nxt = fill_a_r;
    fill_b_nxt = fill_b_r;
    ext_a      = (op_mode == MODE_PA) ? b_top : DW'(in_ch.value);
    ext_b      = a_top;
    wa         = 1'b0;
    wb         = 1'b0;
    sop        = OP_HOLD;
    if (apply) begin
      unique case (op_mode) inside
        MODE_LOAD: begin
          if (full_a) begin
            status = STAT_FULL;
          end else begin
            ctl_a      = '{op: OP_LOAD, inj: INJ_EXT};
            fill_a_nxt = fill_a_r + ONE_V;
          end
        end
        MODE_SA, MODE_SB, MODE_SS: begin
          wa  = (op_mode != MODE_SB);
          wb  = (op_mode != MODE_SA);
          sop = OP_SWAP;
        end
        MODE_RA, MODE_RB, MODE_RR: begin
          wa  = (op_mode != MODE_RB);
          wb  = (op_mode != MODE_RA);
          sop = OP_ROTUP;
        end
        MODE_RRA, MODE_RRB, MODE_RRR: begin
          wa  = (op_mode != MODE_RRB);
          wb  = (op_mode != MODE_RRA);
          sop = OP_DOWN;
        end
        MODE_PA: begin
          if (empty_b) begin
            status = STAT_SHORT;
          end else if (full_a) begin
            status = STAT_FULL;
          end else begin
            ctl_b      = '{op: OP_UP, inj: INJ_EXT};
            ctl_a      = '{op: OP_DOWN, inj: INJ_EXT};
            fill_a_nxt = fill_a_r + ONE_V;
            fill_b_nxt = fill_b_r - ONE_V;
          end
        end
        MODE_PB: begin
          if (empty_a) begin
            status = STAT_SHORT;
          end else if (full_b) begin
            status = STAT_FULL;
          end else begin
            ctl_a      = '{op: OP_UP, inj: INJ_EXT};
            ctl_b      = '{op: OP_DOWN, inj: INJ_EXT};
            fill_b_nxt = fill_b_r + ONE_V;
            fill_a_nxt = fill_a_r - ONE_V;
          end
        end
        default: ;
      endcase

      // swap and rotate families share the per-stack length check
      if (wa) begin
        if (ok_a) begin
          ctl_a.op  = sop;
          ctl_a.inj = (sop == OP_DOWN) ? INJ_BOT : INJ_TOP;
        end else begin
          status = STAT_SHORT;
        end
      end
      if (wb) begin
        if (ok_b) begin
          ctl_b.op  = sop;
          ctl_b.inj = (sop == OP_DOWN) ? INJ_BOT : INJ_TOP;
        end else begin
          status = STAT_SHORT;
        end
      end
    end
  end

  assign out_valid_nxt = apply ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_a_r    <= fill_a_nxt;
      fill_b_r    <= fill_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
    end
    if (apply) begin
      top_a_r  <= (fill_a_nxt != '0) ? a_top_nxt : '0;
      top_b_r  <= (fill_b_nxt != '0) ? b_top_nxt : '0;
      cnt_a_r  <= CNT_W'(fill_a_nxt);
      cnt_b_r  <= CNT_W'(fill_b_nxt);
      status_r <= status;
    end
  end

  assign fill_a            = fill_a_r;
  assign fill_b            = fill_b_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.top_of_a   = top_a_r;
  assign out_ch.top_of_b   = top_b_r;
  assign out_ch.count_of_a = cnt_a_r;
  assign out_ch.count_of_b = cnt_b_r;
  assign out_ch.status     = status_r;

endmodule

// ----- tb/sv/tb_dual_stack_rotate_engine_top.sv -----
// self-checking testbench for dual_stack_rotate_engine_top: a behavioral model of both
// stacks predicts every result beat, a scoreboard compares them in order under random idling
// depends on dsre_pkg, dsre_in_if, dsre_out_if and the engine rtl
module tb_dual_stack_rotate_engine_top;
  import dsre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int PILE_A       = 0;
  localparam int PILE_B       = 1;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_RRR + 4'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

  typedef struct packed {
    logic signed [DW-1:0] top_a;
    logic signed [DW-1:0] top_b;
    logic [CNT_W-1:0]     cnt_a;
    logic [CNT_W-1:0]     cnt_b;
    logic [STAT_W-1:0]    status;
  } stack_view_t;

  logic clk;
  logic rst_n;

  dsre_in_if  in_ch ();
  dsre_out_if out_ch ();

  dual_stack_rotate_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [DW-1:0] pile [2][STACK_DEPTH];
  int                   pile_fill [2];
  stack_view_t          expected_views [$];

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // stack model, entry 0 is the top
  function automatic bit pile_swap(input int s);
    logic signed [DW-1:0] t;
    if (pile_fill[s] < 2) return 1'b0;
    t = pile[s][0];
    pile[s][0] = pile[s][1];
    pile[s][1] = t;
    return 1'b1;
  endfunction

  function automatic bit pile_rotate_up(input int s);
    logic signed [DW-1:0] t;
    int n;
    n = pile_fill[s];
    if (n < 2) return 1'b0;
    t = pile[s][0];
    for (int i = 0; i < n - 1; i++) pile[s][i] = pile[s][i+1];
    pile[s][n-1] = t;
    return 1'b1;
  endfunction

  function automatic bit pile_rotate_down(input int s);
    logic signed [DW-1:0] t;
    int n;
    n = pile_fill[s];
    if (n < 2) return 1'b0;
    t = pile[s][n-1];
    for (int i = n - 1; i > 0; i--) pile[s][i] = pile[s][i-1];
    pile[s][0] = t;
    return 1'b1;
  endfunction

  function automatic logic [STAT_W-1:0] pile_move(input int src, input int dst);
    logic signed [DW-1:0] v;
    if (pile_fill[src] == 0) return STAT_SHORT;
    if (pile_fill[dst] >= STACK_DEPTH) return STAT_FULL;
    v = pile[src][0];
    for (int i = 0; i < pile_fill[src] - 1; i++) pile[src][i] = pile[src][i+1];
    pile_fill[src]--;
    for (int i = pile_fill[dst]; i > 0; i--) pile[dst][i] = pile[dst][i-1];
    pile[dst][0] = v;
    pile_fill[dst]++;
    return STAT_DONE;
  endfunction

  function automatic stack_view_t apply_op(input logic [MODE_W-1:0] m,
                                           input logic signed [DW-1:0] v);
    stack_view_t view;
    logic [STAT_W-1:0] st;
    bit ok_a, ok_b;
    st = STAT_DONE;
    case (m)
      MODE_LOAD: begin
        if (pile_fill[PILE_A] >= STACK_DEPTH) begin
          st = STAT_FULL;
        end else begin
          pile[PILE_A][pile_fill[PILE_A]] = v;
          pile_fill[PILE_A]++;
        end
      end
      MODE_SA:  if (!pile_swap(PILE_A)) st = STAT_SHORT;
      MODE_SB:  if (!pile_swap(PILE_B)) st = STAT_SHORT;
      MODE_SS: begin
        ok_a = pile_swap(PILE_A);
        ok_b = pile_swap(PILE_B);
        if (!ok_a || !ok_b) st = STAT_SHORT;
      end
      MODE_PA:  st = pile_move(PILE_B, PILE_A);
      MODE_PB:  st = pile_move(PILE_A, PILE_B);
      MODE_RA:  if (!pile_rotate_up(PILE_A)) st = STAT_SHORT;
      MODE_RB:  if (!pile_rotate_up(PILE_B)) st = STAT_SHORT;
      MODE_RR: begin
        ok_a = pile_rotate_up(PILE_A);
        ok_b = pile_rotate_up(PILE_B);
        if (!ok_a || !ok_b) st = STAT_SHORT;
      end
      MODE_RRA: if (!pile_rotate_down(PILE_A)) st = STAT_SHORT;
      MODE_RRB: if (!pile_rotate_down(PILE_B)) st = STAT_SHORT;
      MODE_RRR: begin
        ok_a = pile_rotate_down(PILE_A);
        ok_b = pile_rotate_down(PILE_B);
        if (!ok_a || !ok_b) st = STAT_SHORT;
      end
      default: st = STAT_DONE;
    endcase
    view.top_a  = (pile_fill[PILE_A] > 0) ? pile[PILE_A][0] : '0;
    view.top_b  = (pile_fill[PILE_B] > 0) ? pile[PILE_B][0] : '0;
    view.cnt_a  = CNT_W'(pile_fill[PILE_A]);
    view.cnt_b  = CNT_W'(pile_fill[PILE_B]);
    view.status = st;
    return view;
  endfunction

  // expectation is queued when the beat is offered; valid then holds until accepted
  task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [DW-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    expected_views.push_back(apply_op(m, v));
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(input int load_pct);
    int r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(99);
    if (r < load_pct) m = MODE_LOAD;
    else if (r >= 97) m = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    else m = MODE_W'($urandom_range(MODE_RRR, MODE_SA));
    return m;
  endfunction

  task automatic note_mismatch(input stack_view_t want, input stack_view_t got,
                               input bit orphan);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0s: exp top_a %0d top_b %0d cnt_a %0d cnt_b %0d st %0d",
               orphan ? "beat with nothing expected" : "result mismatch",
               want.top_a, want.top_b, want.cnt_a, want.cnt_b, want.status);
      $display("  got top_a %0d top_b %0d cnt_a %0d cnt_b %0d st %0d",
               got.top_a, got.top_b, got.cnt_a, got.cnt_b, got.status);
    end
  endtask

  always @(posedge clk) begin
    stack_view_t got;
    stack_view_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.top_a  = out_ch.top_of_a;
      got.top_b  = out_ch.top_of_b;
      got.cnt_a  = out_ch.count_of_a;
      got.cnt_b  = out_ch.count_of_b;
      got.status = out_ch.status;
      if (expected_views.size() == 0) begin
        note_mismatch('0, got, 1'b1);
      end else begin
        want = expected_views.pop_front();
        if (got.top_a !== want.top_a || got.top_b !== want.top_b ||
            got.cnt_a !== want.cnt_a || got.cnt_b !== want.cnt_b ||
            got.status !== want.status) begin
          note_mismatch(want, got, 1'b0);
        end
      end
    end
  end

  // result side: random idling plus an occasional long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic test_empty_stacks();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_op(MODE_SA, $urandom());
    send_op(MODE_SS, $urandom());
    send_op(MODE_PA, $urandom());
    send_op(MODE_PB, $urandom());
    send_op(MODE_RR, $urandom());
    send_op(MODE_RRR, $urandom());
    send_op(MODE_RRB, $urandom());
  endtask

  task automatic test_directed_ops();
    send_op(MODE_LOAD, 32'sh8000_0000);
    send_op(MODE_LOAD, 32'sh7fff_ffff);
    send_op(MODE_LOAD, -32'sd1);
    send_op(MODE_LOAD, 32'sd0);
    send_op(MODE_LOAD, $urandom());
    send_op(MODE_SA, $urandom());
    send_op(MODE_PB, $urandom());
    // one element in b: combined ops change a only
    send_op(MODE_RR, $urandom());
    send_op(MODE_RRR, $urandom());
    send_op(MODE_SS, $urandom());
    send_op(MODE_PB, $urandom());
    send_op(MODE_SB, $urandom());
    send_op(MODE_SS, $urandom());
    send_op(MODE_RB, $urandom());
    send_op(MODE_RRB, $urandom());
    send_op(MODE_PA, $urandom());
    send_op(MODE_RA, $urandom());
    send_op(MODE_RRA, $urandom());
    send_op(MODE_SPARE_FIRST, $urandom());
    send_op(MODE_SPARE_LAST, $urandom());
  endtask

  task automatic test_random_ops(input int n, input int tx_pct, input int rx_pct);
    int load_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      load_pct = (pile_fill[PILE_A] + pile_fill[PILE_B] < 6) ? 35 : 4;
      send_op(pick_mode(load_pct), $urandom());
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    repeat (50) send_op(pick_mode(10), $urandom());
  endtask

  task automatic test_full_stores();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    while (pile_fill[PILE_A] < STACK_DEPTH) send_op(MODE_LOAD, $urandom());
    send_op(MODE_LOAD, $urandom());
    while (pile_fill[PILE_B] < STACK_DEPTH) send_op(MODE_PB, $urandom());
    while (pile_fill[PILE_A] < STACK_DEPTH) send_op(MODE_LOAD, $urandom());
    send_op(MODE_PB, $urandom());
    send_op(MODE_PA, $urandom());
    send_op(MODE_LOAD, $urandom());
    send_op(MODE_SS, $urandom());
    send_op(MODE_RR, $urandom());
    send_op(MODE_RRR, $urandom());
    send_op(MODE_RA, $urandom());
    send_op(MODE_RRB, $urandom());
    send_op(MODE_RB, $urandom());
    send_op(MODE_RRA, $urandom());
    send_op(MODE_SA, $urandom());
    send_op(MODE_SB, $urandom());
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_LOAD;
    in_ch.value <= '0;
    pile_fill[PILE_A] = 0;
    pile_fill[PILE_B] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stacks();
    test_directed_ops();
    test_random_ops(600, 33, 73);
    test_random_ops(600, 73, 33);
    test_output_backpressure();
    test_random_ops(600, 0, 0);
    test_full_stores();

    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
